/* sv/pfx_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package pfx_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int PTR_W = $clog2(STACK_DEPTH);
    localparam int CNT_W = $clog2(STACK_DEPTH + 1);

    localparam logic [7:0] SYM_ADD   = 8'h2B;
    localparam logic [7:0] SYM_SUB   = 8'h2D;
    localparam logic [7:0] SYM_MUL   = 8'h2A;
    localparam logic [7:0] SYM_DIV   = 8'h2F;
    localparam logic [7:0] SYM_MOD   = 8'h25;
    localparam logic [7:0] SYM_POW   = 8'h24;
    localparam logic [7:0] SYM_ZERO  = 8'h30;
    localparam logic [7:0] SYM_SPACE = 8'h20;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_UNDER = 3'd1;
    localparam logic [2:0] ST_OVER  = 3'd2;
    localparam logic [2:0] ST_DIVZ  = 3'd3;
    localparam logic [2:0] ST_COUNT = 3'd4;

    // controller to datapath
    typedef struct packed {
        logic       load;      // capture input symbol
        logic       rd_b;      // read second top
        logic       push_num;  // push symbol - '0'
        logic       op_start;  // set up operator work
        logic       div_step;  // one restoring division step
        logic       pow_step;  // one square-and-multiply step
        logic       mul_fix;   // register multiply result
        logic       push_res;  // push computed result
        logic       emit;      // load output register
        logic       clear;     // clear count and error
    } pfx_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic       is_space;
        logic       is_op;
        logic       is_divmod;
        logic       is_pow;
        logic       is_mul;
        logic       err;
        logic       iter_done;
        logic       out_busy;
    } pfx_sts_t;

endpackage
`default_nettype wire

/* sv/pfx_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface pfx_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;
    logic       final_req;
    modport source (output valid, symbol, final_req, input ready);
    modport sink   (input valid, symbol, final_req, output ready);
endinterface

interface pfx_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value;
    logic [2:0]         status;
    modport source (output valid, value, status, input ready);
    modport sink   (input valid, value, status, output ready);
endinterface
`default_nettype wire

/* sv/pfx_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
module pfx_datapath
    import pfx_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic [7:0] in_symbol,
    input  wire pfx_cmd_t cmd,
    output pfx_sts_t      sts,
    output logic          out_valid,
    input  wire logic     out_ready,
    output logic [31:0]   out_value,
    output logic [2:0]    out_status
);

    logic [31:0] mem [STACK_DEPTH];
    logic [CNT_W-1:0] cnt_reg;
    logic [2:0]  err_reg;
    logic [7:0]  sym_reg;
    logic [31:0] a_reg, b_reg, bot_reg, rd_data;
    logic [PTR_W-1:0] rd_addr;
    logic [31:0] acc_reg, base_reg, exp_reg, rem_reg, quo_reg;
    logic [31:0] dvs_reg;
    logic        qneg_reg, rneg_reg;
    logic [5:0]  it_reg;
    logic [31:0] res_reg;
    logic [31:0] mul_reg;
    logic        ov_valid_reg;
    logic [31:0] ov_value_reg;
    logic [2:0]  ov_status_reg;

    logic is_op;
    assign is_op = (sym_reg == SYM_ADD) || (sym_reg == SYM_SUB) || (sym_reg == SYM_MUL)
        || (sym_reg == SYM_DIV) || (sym_reg == SYM_MOD) || (sym_reg == SYM_POW);

    assign sts.is_space  = (sym_reg == SYM_SPACE);
    assign sts.is_op     = is_op;
    assign sts.is_divmod = (sym_reg == SYM_DIV) || (sym_reg == SYM_MOD);
    assign sts.is_pow    = (sym_reg == SYM_POW);
    assign sts.is_mul    = (sym_reg == SYM_MUL);
    assign sts.err       = (err_reg != ST_OK);
    assign sts.iter_done = (it_reg == 6'd0);
    assign sts.out_busy  = ov_valid_reg;

    // read address: top on load, second top on rd_b
    always_comb
    begin
        if (cmd.rd_b)
            rd_addr = PTR_W'(cnt_reg - CNT_W'(2));
        else
            rd_addr = PTR_W'(cnt_reg - CNT_W'(1));
    end

    logic push_en;
    logic [31:0] push_val;
    logic [PTR_W-1:0] push_addr;
    assign push_en = cmd.push_res || (cmd.push_num && (cnt_reg != CNT_W'(STACK_DEPTH)));
    assign push_val = cmd.push_num ? (32'(sym_reg) - 32'(SYM_ZERO)) : res_reg;
    assign push_addr = cmd.push_num ? PTR_W'(cnt_reg) : PTR_W'(cnt_reg - CNT_W'(2));

    // stack memory
    always_ff @(posedge clk)
    begin
        if (push_en)
            mem[push_addr] <= push_val;
        rd_data <= mem[rd_addr];
        bot_reg <= mem[0];
    end

    logic [31:0] abs_a, abs_b, prod, sub_try;
    assign abs_a = a_reg[31] ? (32'd0 - a_reg) : a_reg;
    assign abs_b = b_reg[31] ? (32'd0 - b_reg) : b_reg;
    assign prod  = acc_reg * base_reg;
    logic [32:0] rem_sh;
    assign rem_sh = {rem_reg, quo_reg[31]};

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sym_reg <= in_symbol;
        end
        if (cmd.rd_b)
            a_reg <= rd_data;
        if (cmd.op_start)
        begin
            b_reg <= rd_data;
        end
        // operator setup happens in the first div or pow step after b is captured; multiply uses mul_fix
        if (cmd.div_step)
        begin
            if (it_reg == 6'd33)
            begin
                rem_reg  <= 32'd0;
                quo_reg  <= abs_a;
                dvs_reg  <= abs_b;
                qneg_reg <= a_reg[31] ^ b_reg[31];
                rneg_reg <= a_reg[31];
                acc_reg  <= 32'd1;
            end
            else if (it_reg != 6'd0)
            begin
                if (rem_sh >= {1'b0, dvs_reg})
                begin
                    rem_reg <= 32'(rem_sh - {1'b0, dvs_reg});
                    quo_reg <= {quo_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh[31:0];
                    quo_reg <= {quo_reg[30:0], 1'b0};
                end
            end
        end
        // square and multiply, one exponent bit per step
        if (cmd.pow_step)
        begin
            if (it_reg == 6'd33)
            begin
                acc_reg  <= 32'd1;
                base_reg <= a_reg;
                exp_reg  <= b_reg;
            end
            else if (it_reg != 6'd0)
            begin
                if (exp_reg[0])
                    acc_reg <= prod;
                base_reg <= base_reg * base_reg;
                exp_reg  <= exp_reg >> 1;
            end
        end
        if (cmd.mul_fix)
            mul_reg <= a_reg * b_reg;
    end

    // iteration counter and result selection
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            it_reg <= 6'd0;
        end
        else if (cmd.op_start)
        begin
            it_reg <= 6'd33;
        end
        else if ((cmd.div_step || cmd.pow_step) && it_reg != 6'd0)
        begin
            if (cmd.pow_step && it_reg == 6'd33)
                it_reg <= 6'd32;
            else
                it_reg <= it_reg - 6'd1;
        end
    end

    logic [31:0] res_next;
    logic        divz;
    always_comb
    begin
        divz = 1'b0;
        res_next = 32'd0;
        case (sym_reg)
            SYM_ADD: res_next = a_reg + b_reg;
            SYM_SUB: res_next = a_reg - b_reg;
            SYM_MUL: res_next = mul_reg;
            SYM_DIV:
            begin
                divz = (b_reg == 32'd0);
                res_next = qneg_reg ? (32'd0 - quo_reg) : quo_reg;
            end
            SYM_MOD:
            begin
                divz = (b_reg == 32'd0);
                res_next = rneg_reg ? (32'd0 - rem_reg) : rem_reg;
            end
            default:
            begin
                if (b_reg[31])
                begin
                    if (a_reg == 32'd1)
                        res_next = 32'd1;
                    else if (a_reg == 32'hFFFF_FFFF)
                        res_next = b_reg[0] ? 32'hFFFF_FFFF : 32'd1;
                    else
                    begin
                        res_next = 32'd0;
                        divz = (a_reg == 32'd0);
                    end
                end
                else
                    res_next = acc_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    // count, error and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            err_reg       <= ST_OK;
            ov_valid_reg  <= 1'b0;
            ov_value_reg  <= 32'd0;
            ov_status_reg <= ST_OK;
        end
        else
        begin
            if (ov_valid_reg && out_ready)
                ov_valid_reg <= 1'b0;
            if (cmd.rd_b && cnt_reg < CNT_W'(2))
                err_reg <= ST_UNDER;
            if (cmd.push_num)
            begin
                if (cnt_reg == CNT_W'(STACK_DEPTH))
                    err_reg <= ST_OVER;
                else
                    cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (cmd.push_res)
            begin
                if (divz)
                    err_reg <= ST_DIVZ;
                else
                    cnt_reg <= cnt_reg - CNT_W'(1);
            end
            if (cmd.emit)
            begin
                ov_valid_reg <= 1'b1;
                if (err_reg != ST_OK)
                begin
                    ov_status_reg <= err_reg;
                    ov_value_reg  <= 32'd0;
                end
                else if (cnt_reg == CNT_W'(1))
                begin
                    ov_status_reg <= ST_OK;
                    ov_value_reg  <= bot_reg;
                end
                else
                begin
                    ov_status_reg <= ST_COUNT;
                    ov_value_reg  <= 32'd0;
                end
            end
            if (cmd.clear)
            begin
                cnt_reg <= '0;
                err_reg <= ST_OK;
            end
        end
    end

    assign out_valid  = ov_valid_reg;
    assign out_value  = ov_value_reg;
    assign out_status = ov_status_reg;

endmodule
`default_nettype wire

/* sv/pfx_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
module pfx_ctrl
    import pfx_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire logic     in_final,
    input  wire pfx_sts_t sts,
    output pfx_cmd_t      cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DEC   = 4'd1;
    localparam logic [3:0] S_RDB   = 4'd2;
    localparam logic [3:0] S_CHK   = 4'd3;
    localparam logic [3:0] S_GETB  = 4'd4;
    localparam logic [3:0] S_DIV   = 4'd5;
    localparam logic [3:0] S_POW   = 4'd6;
    localparam logic [3:0] S_MUL   = 4'd7;
    localparam logic [3:0] S_RES   = 4'd8;
    localparam logic [3:0] S_PUSH  = 4'd9;
    localparam logic [3:0] S_FIN   = 4'd10;
    localparam logic [3:0] S_EMIT  = 4'd11;

    logic [3:0] state_reg, state_next;
    logic       fin_reg, fin_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fin_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fin_reg   <= fin_next;
        end
    end

    // sequence one symbol
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        fin_next   = fin_reg;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    fin_next   = in_final;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                if (sts.err || sts.is_space)
                    state_next = S_FIN;
                else if (sts.is_op)
                    state_next = S_RDB;
                else
                begin
                    cmd.push_num = 1'b1;
                    state_next   = S_FIN;
                end
            end
            S_RDB:
            begin
                cmd.rd_b   = 1'b1;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (sts.err)
                    state_next = S_FIN;
                else
                begin
                    cmd.op_start = 1'b1;
                    state_next   = S_GETB;
                end
            end
            S_GETB:
            begin
                if (sts.is_divmod)
                    state_next = S_DIV;
                else if (sts.is_pow)
                    state_next = S_POW;
                else
                    state_next = S_MUL;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.iter_done)
                    state_next = S_RES;
            end
            S_POW:
            begin
                cmd.pow_step = 1'b1;
                if (sts.iter_done)
                    state_next = S_RES;
            end
            S_MUL:
            begin
                if (sts.is_mul)
                    cmd.mul_fix = 1'b1;
                state_next = S_RES;
            end
            S_RES:
            begin
                state_next = S_PUSH;
            end
            S_PUSH:
            begin
                cmd.push_res = 1'b1;
                state_next   = S_FIN;
            end
            S_FIN:
            begin
                if (!fin_reg)
                    state_next = S_IDLE;
                else if (!sts.out_busy)
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                cmd.emit   = 1'b1;
                cmd.clear  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

/* sv/prefix_expression_evaluator.sv */
`timescale 1ns / 1ps
`default_nettype none
// Channel  Dir  Payload
// in       in   symbol[7:0], final_req
// out      out  value[31:0] signed, status[2:0]
//
// A number is pushed and a space skipped; + - and * compute directly,
// while / % $ run the 32-step shared divide and power sequencer.
// A symbol after an error is skipped; an operator that underflows stops
// at its check. A final beat also loads the output register.
// Reset clears the stack count, error and output valid; stack contents
// are undefined. The output register holds its beat until taken, and a
// final beat waits only while that register is still full.
module prefix_expression_evaluator
    import pfx_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    pfx_in_if.sink    in_ch,
    pfx_out_if.source out_ch
);

    pfx_cmd_t cmd;
    pfx_sts_t sts;
    logic [31:0] value_w;

    pfx_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .in_final (in_ch.final_req),
        .sts      (sts),
        .cmd      (cmd)
    );

    pfx_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_symbol  (in_ch.symbol),
        .cmd        (cmd),
        .sts        (sts),
        .out_valid  (out_ch.valid),
        .out_ready  (out_ch.ready),
        .out_value  (value_w),
        .out_status (out_ch.status)
    );

    assign out_ch.value = value_w;

endmodule
`default_nettype wire
